// ===== rtl/rrfp_pkg.sv =====
// ----------------------------------------------------------------------------
// rrfp_pkg
// Shared types and constants of the reader response frame parser.
// ----------------------------------------------------------------------------
package rrfp_pkg;

    localparam logic [7:0] PREAMBLE = 8'hBD;

    // count of stored data bytes, wide enough for a store of up to 127 bytes
    localparam int CNT_W = 7;

    // configuration register indexes
    localparam logic [2:0] CFG_CODE_LOGIN      = 3'd0;
    localparam logic [2:0] CFG_CODE_READ       = 3'd1;
    localparam logic [2:0] CFG_CODE_WRITE      = 3'd2;
    localparam logic [2:0] CFG_STATUS_OK       = 3'd3;
    localparam logic [2:0] CFG_STATUS_NO_CARD  = 3'd4;
    localparam logic [2:0] CFG_STATUS_LOGIN_OK = 3'd5;

    // verdict codes
    localparam logic [3:0] V_CKSUM_ERR  = 4'd0;
    localparam logic [3:0] V_NO_TAG     = 4'd1;
    localparam logic [3:0] V_LOGIN_OK   = 4'd2;
    localparam logic [3:0] V_LOGIN_FAIL = 4'd3;
    localparam logic [3:0] V_READ_OK    = 4'd4;
    localparam logic [3:0] V_READ_FAIL  = 4'd5;
    localparam logic [3:0] V_WRITE_OK   = 4'd6;
    localparam logic [3:0] V_WRITE_FAIL = 4'd7;
    localparam logic [3:0] V_OK         = 4'd8;
    localparam logic [3:0] V_FAIL       = 4'd9;
    localparam logic [3:0] V_MALFORMED  = 4'd10;

    // one job per finished frame or too-short length, handed from the parser to the emitter
    typedef struct packed {
        logic [7:0]       command;
        logic [7:0]       status;
        logic [3:0]       verdict;
        logic             overflow;
        logic [CNT_W-1:0] count;     // data bytes to emit before the verdict
    } t_job;

    // tag store write request
    typedef struct packed {
        logic             we;
        logic [CNT_W-1:0] addr;
        logic [7:0]       data;
    } t_wr_req;

    // queue status seen by the parser
    typedef struct packed {
        logic not_empty;
        logic full;
    } t_q_status;

endpackage

// ===== rtl/rrfp_front.sv =====
// ----------------------------------------------------------------------------
// rrfp_front
// Frame parser: preamble hunt, length, command, status, data and checksum.
// Keeps the configuration registers and posts one job per finished frame or too-short length.
// ----------------------------------------------------------------------------
module rrfp_front
    import rrfp_pkg::*;
#(
    parameter int TAG_BYTES = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_rx_byte,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_idx,
    input  logic [7:0] i_cfg_data,
    input  t_q_status  i_q_status,
    input  logic       i_back_busy,
    output logic       o_push,
    output t_job       o_job,
    output t_wr_req    o_wr
);

    localparam logic [CNT_W-1:0] TagMax = CNT_W'(TAG_BYTES);

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_LEN,
        PH_BODY,
        PH_CKSUM
    } t_phase;

    t_phase           r_phase, n_phase;
    logic [7:0]       r_left, n_left;
    logic [7:0]       r_xor, n_xor;
    logic [7:0]       r_cmd, n_cmd;
    logic [7:0]       r_stat, n_stat;
    logic [1:0]       r_body, n_body;     // 0 command, 1 status, 2 data
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_ovf, n_ovf;

    logic [7:0] r_code_login, r_code_read, r_code_write;
    logic [7:0] r_st_ok, r_st_no_card, r_st_login_ok;

    logic       accept;
    logic       store_byte;
    logic [3:0] judged;

    assign store_byte = (r_phase == PH_BODY) && (r_body == 2'd2) && (r_cnt < TagMax);

    // hold off store writes while the store may be read, and length/checksum on a full queue
    always_comb begin
        o_in_stall = 1'b0;
        case (r_phase)
            PH_LEN:   o_in_stall = i_q_status.full;
            PH_CKSUM: o_in_stall = i_q_status.full;
            PH_BODY:  o_in_stall = store_byte && (i_q_status.not_empty || i_back_busy);
            default:  o_in_stall = 1'b0;
        endcase
    end

    assign accept = i_in_valid && !o_in_stall;

    always_comb begin
        if (r_stat == r_st_no_card) begin
            judged = V_NO_TAG;
        end else if (r_cmd == r_code_login) begin
            judged = (r_stat == r_st_login_ok) ? V_LOGIN_OK : V_LOGIN_FAIL;
        end else if (r_cmd == r_code_read) begin
            judged = (r_stat == r_st_ok) ? V_READ_OK : V_READ_FAIL;
        end else if (r_cmd == r_code_write) begin
            judged = (r_stat == r_st_ok) ? V_WRITE_OK : V_WRITE_FAIL;
        end else begin
            judged = (r_stat == r_st_ok) ? V_OK : V_FAIL;
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_left  = r_left;
        n_xor   = r_xor;
        n_cmd   = r_cmd;
        n_stat  = r_stat;
        n_body  = r_body;
        n_cnt   = r_cnt;
        n_ovf   = r_ovf;
        o_push  = 1'b0;
        o_job   = '0;
        o_wr    = '0;
        o_wr.addr = r_cnt;
        o_wr.data = i_rx_byte;
        if (accept) begin
            case (r_phase)
                PH_HUNT: begin
                    if (i_rx_byte == PREAMBLE) begin
                        n_xor   = PREAMBLE;
                        n_phase = PH_LEN;
                    end
                end
                PH_LEN: begin
                    if (i_rx_byte < 8'd3) begin
                        o_push        = 1'b1;
                        o_job.verdict = V_MALFORMED;
                        n_phase       = PH_HUNT;
                    end else begin
                        n_xor   = r_xor ^ i_rx_byte;
                        n_left  = i_rx_byte - 8'd1;
                        n_body  = 2'd0;
                        n_cnt   = '0;
                        n_ovf   = 1'b0;
                        n_cmd   = 8'd0;
                        n_stat  = 8'd0;
                        n_phase = PH_BODY;
                    end
                end
                PH_BODY: begin
                    n_xor = r_xor ^ i_rx_byte;
                    if (r_body == 2'd0) begin
                        n_cmd = i_rx_byte;
                    end else if (r_body == 2'd1) begin
                        n_stat = i_rx_byte;
                    end else if (store_byte) begin
                        o_wr.we = 1'b1;
                        n_cnt   = r_cnt + CNT_W'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (r_body != 2'd2) begin
                        n_body = r_body + 2'd1;
                    end
                    n_left = r_left - 8'd1;
                    if (r_left == 8'd1) begin
                        n_phase = PH_CKSUM;
                    end
                end
                default: begin
                    o_push         = 1'b1;
                    o_job.status   = r_stat;
                    o_job.overflow = r_ovf;
                    if (i_rx_byte != r_xor) begin
                        o_job.verdict = V_CKSUM_ERR;
                    end else begin
                        o_job.verdict = judged;
                        o_job.command = r_cmd;
                        o_job.count   = (judged == V_READ_OK) ? r_cnt : '0;
                    end
                    n_phase = PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_HUNT;
            r_left        <= '0;
            r_xor         <= '0;
            r_cmd         <= '0;
            r_stat        <= '0;
            r_body        <= '0;
            r_cnt         <= '0;
            r_ovf         <= 1'b0;
            r_code_login  <= 8'd2;
            r_code_read   <= 8'd3;
            r_code_write  <= 8'd4;
            r_st_ok       <= 8'd0;
            r_st_no_card  <= 8'd1;
            r_st_login_ok <= 8'd2;
        end else begin
            r_phase <= n_phase;
            r_left  <= n_left;
            r_xor   <= n_xor;
            r_cmd   <= n_cmd;
            r_stat  <= n_stat;
            r_body  <= n_body;
            r_cnt   <= n_cnt;
            r_ovf   <= n_ovf;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_CODE_LOGIN:      r_code_login  <= i_cfg_data;
                    CFG_CODE_READ:       r_code_read   <= i_cfg_data;
                    CFG_CODE_WRITE:      r_code_write  <= i_cfg_data;
                    CFG_STATUS_OK:       r_st_ok       <= i_cfg_data;
                    CFG_STATUS_NO_CARD:  r_st_no_card  <= i_cfg_data;
                    CFG_STATUS_LOGIN_OK: r_st_login_ok <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

// ===== rtl/rrfp_queue.sv =====
// ----------------------------------------------------------------------------
// rrfp_queue
// Two-entry job queue between the parser and the emitter.
// ----------------------------------------------------------------------------
module rrfp_queue
    import rrfp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_job      i_job,
    input  logic      i_pop,
    output t_job      o_job,
    output t_q_status o_status
);

    t_job       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_job            = r_mem[r_rp];
    assign o_status.not_empty = (r_cnt != 2'd0);
    assign o_status.full      = (r_cnt == 2'd2);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== rtl/rrfp_back.sv =====
// ----------------------------------------------------------------------------
// rrfp_back
// Result emitter: holds the tag store, reads out stored data bytes of a
// successful read, then the verdict, through one output register.
// ----------------------------------------------------------------------------
module rrfp_back
    import rrfp_pkg::*;
#(
    parameter int TAG_BYTES = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_wr_req    i_wr,
    input  logic       i_q_valid,
    input  t_job       i_job,
    output logic       o_pop,
    output logic       o_busy,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_kind,
    output logic [7:0] o_data_byte,
    output logic [7:0] o_command_code,
    output logic [7:0] o_status_code,
    output logic [3:0] o_verdict,
    output logic       o_data_overflow,
    output logic       o_last
);

    localparam int AW = (TAG_BYTES > 1) ? $clog2(TAG_BYTES) : 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_DATA,
        ST_VERD
    } t_state;

    logic [7:0]       r_store [TAG_BYTES];
    logic [7:0]       r_rd_data;
    t_state           r_state;
    t_job             r_job;
    logic [CNT_W-1:0] r_idx;
    logic             out_free;
    logic             out_load;

    assign out_free = !o_out_valid || !i_out_stall;
    assign out_load = out_free && ((r_state == ST_DATA) || (r_state == ST_VERD));
    assign o_pop    = (r_state == ST_IDLE) && i_q_valid;
    assign o_busy   = (r_state != ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_store[i_wr.addr[AW-1:0]] <= i_wr.data;
        end
        r_rd_data <= r_store[r_idx[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (out_free && !out_load) begin
                o_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_q_valid) begin
                        r_job   <= i_job;
                        r_idx   <= '0;
                        r_state <= (i_job.count == '0) ? ST_VERD : ST_READ;
                    end
                end
                ST_READ: begin
                    r_state <= ST_DATA;
                end
                ST_DATA: begin
                    if (out_free) begin
                        o_out_valid     <= 1'b1;
                        o_kind          <= 1'b0;
                        o_data_byte     <= r_rd_data;
                        o_command_code  <= r_job.command;
                        o_status_code   <= r_job.status;
                        o_verdict       <= V_READ_OK;
                        o_data_overflow <= r_job.overflow;
                        o_last          <= 1'b0;
                        r_idx           <= r_idx + CNT_W'(1);
                        r_state <= (r_idx + CNT_W'(1) == r_job.count) ? ST_VERD : ST_READ;
                    end
                end
                default: begin
                    if (out_free) begin
                        o_out_valid     <= 1'b1;
                        o_kind          <= 1'b1;
                        o_data_byte     <= 8'd0;
                        o_command_code  <= r_job.command;
                        o_status_code   <= r_job.status;
                        o_verdict       <= r_job.verdict;
                        o_data_overflow <= r_job.overflow;
                        o_last          <= 1'b1;
                        r_state         <= ST_IDLE;
                    end
                end
            endcase
        end
    end

endmodule

// ===== rtl/reader_response_frame_parser.sv =====
// path: a frame's first result passes the queue, the emitter state and the output
// register, a data byte the store read too; output stalls add to both
// throughput: 1 received byte per cycle; a data byte to store waits while a job is
// queued or read out, length and checksum bytes wait while the queue is full
// readout: per stored byte a store read (one port), then a load; then the verdict
// reset: synchronous, active low; tag store not cleared and needs no clearing pass
// ----------------------------------------------------------------------------
// reader_response_frame_parser
// Top level: parser front, job queue and result emitter.
// ----------------------------------------------------------------------------
module reader_response_frame_parser
    import rrfp_pkg::*;
#(
    parameter int TAG_BYTES = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_rx_byte,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_idx,
    input  logic [7:0] i_cfg_data,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_kind,
    output logic [7:0] o_data_byte,
    output logic [7:0] o_command_code,
    output logic [7:0] o_status_code,
    output logic [3:0] o_verdict,
    output logic       o_data_overflow,
    output logic       o_last
);

    t_q_status q_status;
    t_job      push_job;
    t_job      head_job;
    t_wr_req   wr_req;
    logic      push;
    logic      pop;
    logic      back_busy;

    rrfp_front #(
        .TAG_BYTES (TAG_BYTES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_rx_byte   (i_rx_byte),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_q_status  (q_status),
        .i_back_busy (back_busy),
        .o_push      (push),
        .o_job       (push_job),
        .o_wr        (wr_req)
    );

    rrfp_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_job    (push_job),
        .i_pop    (pop),
        .o_job    (head_job),
        .o_status (q_status)
    );

    rrfp_back #(
        .TAG_BYTES (TAG_BYTES)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_wr            (wr_req),
        .i_q_valid       (q_status.not_empty),
        .i_job           (head_job),
        .o_pop           (pop),
        .o_busy          (back_busy),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_kind          (o_kind),
        .o_data_byte     (o_data_byte),
        .o_command_code  (o_command_code),
        .o_status_code   (o_status_code),
        .o_verdict       (o_verdict),
        .o_data_overflow (o_data_overflow),
        .o_last          (o_last)
    );

`ifndef NO_ASSERTIONS
    // store must not change under a readout in progress
    a_no_write_during_readout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_req.we |-> (!back_busy && !q_status.not_empty))
        else $error("tag store written during readout");

    // no push into a full queue
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_status.full)
        else $error("job queue overrun");

    // verdicts close a frame, data bytes never do
    a_last_on_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_kind == o_last))
        else $error("last flag does not match result kind");
`endif

endmodule

// ===== verif/frame_result_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// frame_result_checker
// Watches the byte, register and result channels of the frame parser, tracks
// the frame it is parsing and compares each result transfer against the next
// result that the received bytes call for.
// ----------------------------------------------------------------------------
module frame_result_checker
    import rrfp_pkg::*;
#(
    parameter int TAG_BYTES = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  logic [7:0] i_rx_byte,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_idx,
    input  logic [7:0] i_cfg_data,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  logic       i_kind,
    input  logic [7:0] i_data_byte,
    input  logic [7:0] i_command_code,
    input  logic [7:0] i_status_code,
    input  logic [3:0] i_verdict,
    input  logic       i_data_overflow,
    input  logic       i_last,
    output int         o_mismatches,
    output int         o_pending,
    output int         o_results_seen
);

    localparam logic [7:0] MIN_FRAME_LEN = 8'd3;
    localparam int         PRINT_CAP     = 40;

    typedef enum logic [1:0] {
        SEEK_PREAMBLE,
        TAKE_LEN,
        TAKE_BODY,
        TAKE_CKSUM
    } t_parse_phase;

    typedef struct {
        logic       kind;
        logic [7:0] data_byte;
        logic [7:0] command_code;
        logic [7:0] status_code;
        logic [3:0] verdict;
        logic       overflow;
        logic       last;
    } t_frame_result;

    t_parse_phase  phase;
    logic [7:0]    remaining;
    logic [7:0]    xor_acc;
    logic [7:0]    frm_cmd;
    logic [7:0]    frm_status;
    logic [7:0]    body_pos;
    logic [7:0]    tag_bytes [TAG_BYTES];
    int            stored;
    logic          ovf;

    logic [7:0]    reg_login;
    logic [7:0]    reg_read;
    logic [7:0]    reg_write;
    logic [7:0]    reg_ok;
    logic [7:0]    reg_no_card;
    logic [7:0]    reg_login_ok;

    t_frame_result frame_outputs [$];

    initial begin
        o_mismatches   = 0;
        o_pending      = 0;
        o_results_seen = 0;
    end

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        if (o_mismatches < PRINT_CAP) begin
            $display("%0t mismatch on %s: got %0h, want %0h", $time, what, got, want);
        end
        o_mismatches++;
    endtask

    task automatic check_field(input string what, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want) begin
            report_mismatch(what, got, want);
        end
    endtask

    task automatic queue_result(input logic kind, input logic [7:0] data,
                                input logic [7:0] cmd, input logic [7:0] st,
                                input logic [3:0] v, input logic of, input logic lst);
        t_frame_result r;
        r.kind         = kind;
        r.data_byte    = data;
        r.command_code = cmd;
        r.status_code  = st;
        r.verdict      = v;
        r.overflow     = of;
        r.last         = lst;
        frame_outputs.push_back(r);
    endtask

    // no-card status wins over every command
    function automatic logic [3:0] classify_frame();
        if (frm_status == reg_no_card) return V_NO_TAG;
        if (frm_cmd == reg_login)
            return (frm_status == reg_login_ok) ? V_LOGIN_OK : V_LOGIN_FAIL;
        if (frm_cmd == reg_read) return (frm_status == reg_ok) ? V_READ_OK : V_READ_FAIL;
        if (frm_cmd == reg_write) return (frm_status == reg_ok) ? V_WRITE_OK : V_WRITE_FAIL;
        return (frm_status == reg_ok) ? V_OK : V_FAIL;
    endfunction

    task automatic track_rx_byte(input logic [7:0] b);
        logic [3:0] v;
        int         i;
        case (phase)
            SEEK_PREAMBLE: begin
                if (b == PREAMBLE) begin
                    xor_acc = PREAMBLE;
                    phase   = TAKE_LEN;
                end
            end
            TAKE_LEN: begin
                if (b < MIN_FRAME_LEN) begin
                    queue_result(1'b1, 8'h00, 8'h00, 8'h00, V_MALFORMED, 1'b0, 1'b1);
                    phase = SEEK_PREAMBLE;
                end else begin
                    xor_acc    = xor_acc ^ b;
                    remaining  = b - 8'd1;
                    body_pos   = 8'd0;
                    stored     = 0;
                    ovf        = 1'b0;
                    frm_cmd    = 8'h00;
                    frm_status = 8'h00;
                    phase      = TAKE_BODY;
                end
            end
            TAKE_BODY: begin
                xor_acc = xor_acc ^ b;
                if (body_pos == 8'd0) begin
                    frm_cmd = b;
                end else if (body_pos == 8'd1) begin
                    frm_status = b;
                end else if (stored < TAG_BYTES) begin
                    tag_bytes[stored] = b;
                    stored++;
                end else begin
                    ovf = 1'b1;
                end
                body_pos  = body_pos + 8'd1;
                remaining = remaining - 8'd1;
                if (remaining == 8'd0) phase = TAKE_CKSUM;
            end
            default: begin
                if (b != xor_acc) begin
                    queue_result(1'b1, 8'h00, 8'h00, frm_status, V_CKSUM_ERR, ovf, 1'b1);
                end else begin
                    v = classify_frame();
                    // stored bytes go out only for a good read
                    if (v == V_READ_OK) begin
                        for (i = 0; i < stored; i++) begin
                            queue_result(1'b0, tag_bytes[i], frm_cmd, frm_status,
                                         V_READ_OK, ovf, 1'b0);
                        end
                    end
                    queue_result(1'b1, 8'h00, frm_cmd, frm_status, v, ovf, 1'b1);
                end
                phase = SEEK_PREAMBLE;
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        t_frame_result want;
        if (!i_rst_n) begin
            phase        = SEEK_PREAMBLE;
            remaining    = 8'd0;
            xor_acc      = 8'd0;
            frm_cmd      = 8'd0;
            frm_status   = 8'd0;
            body_pos     = 8'd0;
            stored       = 0;
            ovf          = 1'b0;
            reg_login    = 8'd2;
            reg_read     = 8'd3;
            reg_write    = 8'd4;
            reg_ok       = 8'd0;
            reg_no_card  = 8'd1;
            reg_login_ok = 8'd2;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                o_results_seen++;
                if (frame_outputs.size() == 0) begin
                    report_mismatch("result with nothing pending", {7'd0, i_kind}, 8'h00);
                end else begin
                    want = frame_outputs.pop_front();
                    check_field("kind", {7'd0, i_kind}, {7'd0, want.kind});
                    check_field("data_byte", i_data_byte, want.data_byte);
                    check_field("command_code", i_command_code, want.command_code);
                    check_field("status_code", i_status_code, want.status_code);
                    check_field("verdict", {4'd0, i_verdict}, {4'd0, want.verdict});
                    check_field("data_overflow", {7'd0, i_data_overflow},
                                {7'd0, want.overflow});
                    check_field("last", {7'd0, i_last}, {7'd0, want.last});
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_CODE_LOGIN:      reg_login    = i_cfg_data;
                    CFG_CODE_READ:       reg_read     = i_cfg_data;
                    CFG_CODE_WRITE:      reg_write    = i_cfg_data;
                    CFG_STATUS_OK:       reg_ok       = i_cfg_data;
                    CFG_STATUS_NO_CARD:  reg_no_card  = i_cfg_data;
                    CFG_STATUS_LOGIN_OK: reg_login_ok = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                track_rx_byte(i_rx_byte);
            end
        end
        o_pending <= frame_outputs.size();
    end

endmodule

// ===== verif/tb_reader_response_frame_parser.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_reader_response_frame_parser
// Feeds the frame parser directed and random response frames, noise and
// broken frames under several register settings, with random input gaps and output
// stalls and one long output hold; the checker judges every result.
// ----------------------------------------------------------------------------
module tb_reader_response_frame_parser;
    import rrfp_pkg::*;

    localparam int         CLK_PERIOD      = 10;
    localparam int         RESET_CYCLES    = 8;
    localparam int         TAG_BYTES       = 16;
    localparam int         HOLD_CYCLES     = 300;
    localparam int         DRAIN_CYCLES    = 16;
    localparam int         WATCHDOG_LIMIT  = 5000;
    localparam int         BYTES_PER_PHASE = 22;
    localparam int         PRESSURE_FRAMES = 5;
    localparam logic [2:0] CFG_SPARE_LO    = 3'd6;
    localparam logic [2:0] CFG_SPARE_HI    = 3'd7;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic [7:0] rx_byte   = 8'h00;
    logic       cfg_we    = 1'b0;
    logic [2:0] cfg_idx   = 3'd0;
    logic [7:0] cfg_data  = 8'h00;
    logic       out_stall = 1'b0;
    logic       hold_req  = 1'b0;

    logic       in_stall;
    logic       out_valid;
    logic       kind;
    logic [7:0] data_byte;
    logic [7:0] command_code;
    logic [7:0] status_code;
    logic [3:0] verdict;
    logic       data_overflow;
    logic       last;

    int         mismatches;
    int         pending;
    int         results_seen;

    // stimulus-side copy of the registers, used to build meaningful frames
    logic [7:0] cur_login    = 8'd2;
    logic [7:0] cur_read     = 8'd3;
    logic [7:0] cur_write    = 8'd4;
    logic [7:0] cur_ok       = 8'd0;
    logic [7:0] cur_no_card  = 8'd1;
    logic [7:0] cur_login_ok = 8'd2;

    bit         no_gaps     = 1'b0;
    int         bytes_sent  = 0;
    int         frames_sent = 0;
    int         settings    = 1;
    int         idle_cycles = 0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    reader_response_frame_parser #(
        .TAG_BYTES(TAG_BYTES)
    ) uut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_rx_byte      (rx_byte),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_data     (cfg_data),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_kind         (kind),
        .o_data_byte    (data_byte),
        .o_command_code (command_code),
        .o_status_code  (status_code),
        .o_verdict      (verdict),
        .o_data_overflow(data_overflow),
        .o_last         (last)
    );

    frame_result_checker #(
        .TAG_BYTES(TAG_BYTES)
    ) checker_i (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_rx_byte      (rx_byte),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_data     (cfg_data),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_kind         (kind),
        .i_data_byte    (data_byte),
        .i_command_code (command_code),
        .i_status_code  (status_code),
        .i_verdict      (verdict),
        .i_data_overflow(data_overflow),
        .i_last         (last),
        .o_mismatches   (mismatches),
        .o_pending      (pending),
        .o_results_seen (results_seen)
    );

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic push_byte(input logic [7:0] b);
        int gap;
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_frame(input bit good_cksum, input int n_data, input logic [7:0] cmd,
                              input logic [7:0] st, input bit lead_preamble);
        logic [7:0] sum;
        logic [7:0] len;
        logic [7:0] b;
        int         i;
        len = 8'(n_data + 3);
        sum = PREAMBLE ^ len ^ cmd ^ st;
        push_byte(PREAMBLE);
        push_byte(len);
        push_byte(cmd);
        push_byte(st);
        for (i = 0; i < n_data; i++) begin
            b = 8'($urandom_range(0, 255));
            if ((i == 0 && lead_preamble) || $urandom_range(0, 15) == 0) b = PREAMBLE;
            sum = sum ^ b;
            push_byte(b);
        end
        if (!good_cksum) sum = sum ^ 8'($urandom_range(1, 255));
        push_byte(sum);
        frames_sent++;
    endtask

    task automatic send_random_frame();
        int         pick;
        int         n_data;
        logic [7:0] cmd;
        logic [7:0] st;
        pick = $urandom_range(0, 5);
        case (pick)
            0:       cmd = cur_login;
            3:       cmd = cur_write;
            4:       cmd = 8'($urandom_range(0, 255));
            default: cmd = cur_read;
        endcase
        pick = $urandom_range(0, 4);
        case (pick)
            2:       st = cur_no_card;
            3:       st = cur_login_ok;
            4:       st = 8'($urandom_range(0, 255));
            default: st = cur_ok;
        endcase
        pick = $urandom_range(0, 99);
        if (pick < 65) n_data = $urandom_range(0, 5);
        else if (pick < 90) n_data = $urandom_range(14, 20);
        else n_data = $urandom_range(21, 40);
        send_frame($urandom_range(0, 99) < 85, n_data, cmd, st, 1'b0);
    endtask

    // well-formed frames most of the time, with noise and short lengths between
    task automatic send_random_traffic(input int budget);
        int         stop_at;
        int         pick;
        int         k;
        logic [7:0] b;
        stop_at = bytes_sent + budget;
        while (bytes_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 12) begin
                for (k = 0; k < $urandom_range(1, 3); k++) begin
                    b = 8'($urandom_range(0, 255));
                    if (b == PREAMBLE) b = ~b;
                    push_byte(b);
                end
            end else if (pick < 20) begin
                push_byte(PREAMBLE);
                push_byte(8'($urandom_range(0, 2)));
            end else begin
                no_gaps = ($urandom_range(0, 9) == 0);
                send_random_frame();
                no_gaps = 1'b0;
            end
        end
    endtask

    task automatic drain_block();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        // the last bytes may belong to a frame that is still open
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [7:0] value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(posedge clk);
    endtask

    task automatic load_config(input logic [7:0] login, input logic [7:0] rd,
                               input logic [7:0] wr, input logic [7:0] ok,
                               input logic [7:0] no_card, input logic [7:0] login_ok);
        write_reg(CFG_CODE_LOGIN, login);
        write_reg(CFG_CODE_READ, rd);
        write_reg(CFG_CODE_WRITE, wr);
        write_reg(CFG_STATUS_OK, ok);
        write_reg(CFG_STATUS_NO_CARD, no_card);
        write_reg(CFG_STATUS_LOGIN_OK, login_ok);
        cfg_we       <= 1'b0;
        cur_login    = login;
        cur_read     = rd;
        cur_write    = wr;
        cur_ok       = ok;
        cur_no_card  = no_card;
        cur_login_ok = login_ok;
        settings++;
    endtask

    // result side: stretches of free flow, random stall and solid stall, plus
    // one long hold once the stimulus asks for it
    initial begin : result_side
        int  mode;
        int  run_len;
        int  k;
        bit  hold_done;
        hold_done = 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            mode    = $urandom_range(0, 9);
            run_len = $urandom_range(10, 60);
            for (k = 0; k < run_len; k++) begin
                if (hold_req && !hold_done) break;
                if (mode < 4) out_stall <= 1'b0;
                else if (mode < 9) out_stall <= ($urandom_range(0, 99) < 35);
                else out_stall <= 1'b1;
                @(posedge clk);
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                     idle_cycles, pending);
            $display("Regression FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        int k;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: idle bytes, short lengths, login, read with preamble in
        // the data, bad checksum
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(PREAMBLE);
        push_byte(8'd0);
        push_byte(PREAMBLE);
        push_byte(8'd2);
        send_frame(1'b1, 0, cur_login, cur_login_ok, 1'b0);
        send_frame(1'b1, 2, cur_read, cur_ok, 1'b1);
        send_frame(1'b0, 0, cur_write, cur_ok, 1'b0);

        // fill the block while the result side holds off
        hold_req <= 1'b1;
        no_gaps  = 1'b1;
        for (k = 0; k < PRESSURE_FRAMES; k++) begin
            send_frame(1'b1, $urandom_range(14, 18), cur_read, cur_ok, 1'b0);
        end
        no_gaps = 1'b0;
        send_random_traffic(BYTES_PER_PHASE);
        drain_block();

        load_config(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        send_random_traffic(BYTES_PER_PHASE);
        drain_block();

        load_config(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_random_traffic(BYTES_PER_PHASE);
        drain_block();

        load_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        send_random_traffic(BYTES_PER_PHASE);
        drain_block();

        // back to the power-up codes; writes to unmapped indexes must not land
        load_config(8'd2, 8'd3, 8'd4, 8'd0, 8'd1, 8'd2);
        @(posedge clk);
        write_reg(CFG_SPARE_LO, 8'($urandom_range(0, 255)));
        write_reg(CFG_SPARE_HI, 8'($urandom_range(0, 255)));
        cfg_we <= 1'b0;
        send_random_traffic(BYTES_PER_PHASE);
        drain_block();

        $display("covered %0d received bytes in %0d frames under %0d register settings",
                 bytes_sent, frames_sent, settings);
        $display("%0d results checked, %0d mismatches", results_seen, mismatches);
        if (mismatches == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== reader_response_frame_parser.f =====
rtl/rrfp_pkg.sv
rtl/rrfp_front.sv
rtl/rrfp_queue.sv
rtl/rrfp_back.sv
rtl/reader_response_frame_parser.sv
verif/frame_result_checker.sv
verif/tb_reader_response_frame_parser.sv
